// ----- sv/lru_key_value_cache_top_defines.svh -----
// Assertion macros for the LRU key-value cache.
// Included by the files that carry concurrent assertions; expects clk_i and rst_ni in scope.
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge outside reset.
`define LKV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define LKV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define LKV_ASSERT(label, prop, msg)
`define LKV_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- sv/lkv_pkg.sv -----
// Shared types and constants of the LRU key-value cache.
// Used by lkv_cell and lru_key_value_cache_top; depends on nothing.
`timescale 1ns / 1ps

package lkv_pkg;

  localparam int unsigned Entries = 16;
  localparam int unsigned IdxW    = $clog2(Entries);
  localparam int unsigned CntW    = $clog2(Entries + 1);
  localparam int unsigned KeyW    = 32;
  localparam int unsigned DataW   = 32;
  localparam int unsigned CapW    = 5;

  localparam logic [CapW-1:0] CapReset = CapW'(16);

  localparam logic ActGet = 1'b0;
  localparam logic ActPut = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [KeyW-1:0]  key;
    logic [DataW-1:0] value;
  } entry_t;

  typedef struct packed {
    logic            load;
    logic [KeyW-1:0] key;
  } cell_ctrl_t;

endpackage

// ----- sv/lkv_cell.sv -----
// One cell of the recency-ordered chain: holds one entry and compares its key.
// Depends on lkv_pkg for the entry and control types.
`timescale 1ns / 1ps

module lkv_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lkv_pkg::cell_ctrl_t ctrl_i,
  input  lkv_pkg::entry_t     prev_i,
  output lkv_pkg::entry_t     entry_o,
  output logic                match_o
);

  logic                     valid_q, valid_d;
  logic [lkv_pkg::KeyW-1:0]  key_q, key_d;
  logic [lkv_pkg::DataW-1:0] value_q, value_d;

  // A loaded cell takes the entry of its more recent neighbor.
  always_comb begin
    valid_d = ctrl_i.load ? prev_i.valid : valid_q;
    key_d   = ctrl_i.load ? prev_i.key   : key_q;
    value_d = ctrl_i.load ? prev_i.value : value_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign match_o       = valid_q && (key_q == ctrl_i.key);
  assign entry_o.valid = valid_q;
  assign entry_o.key   = key_q;
  assign entry_o.value = value_q;

endmodule

// ----- sv/lru_key_value_cache_top.sv -----
// Top level of the LRU key-value cache: stream ports, control and the cell chain.
// Depends on lkv_pkg, lkv_cell and lru_key_value_cache_top_defines.svh.
`timescale 1ns / 1ps
`include "lru_key_value_cache_top_defines.svh"

// Fully associative key-value cache with least-recently-used replacement. Entries live in
// a chain of cells kept in recency order, the most recent at the head. Every transaction
// compares its key against all cells at once; a hit or an insert shifts the cells ahead of
// the affected position down by one and loads the head. One transaction is accepted per
// cycle while the output register is empty or being read, and its result appears on the
// output register in the next cycle. Input tuser carries the action (0 get, 1 put), output
// tuser the found flag.
module lru_key_value_cache_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lkv_pkg::CapW-1:0]    cfg_wdata_i,     // capacity
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [63:0]                 s_axis_tdata_i,  // lookup_key[31:0], write_value[63:32]
  input  logic                        s_axis_tuser_i,  // action
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [lkv_pkg::DataW-1:0]   m_axis_tdata_o,  // read_value[31:0]
  output logic                        m_axis_tuser_o   // found
);

  logic [lkv_pkg::CapW-1:0]  capacity_q;
  logic [lkv_pkg::CntW-1:0]  occ_q, occ_d;
  logic [lkv_pkg::CntW-1:0]  eff_cap;
  logic [lkv_pkg::CntW-1:0]  limit;
  logic                      out_valid_q, out_valid_d;
  logic                      out_found_q, out_found_d;
  logic [lkv_pkg::DataW-1:0] out_data_q, out_data_d;

  logic                      in_acc, is_put, any_hit, insert, upd, grow;
  logic [lkv_pkg::KeyW-1:0]  in_key;
  logic [lkv_pkg::DataW-1:0] in_value;
  logic [lkv_pkg::IdxW-1:0]  hit_idx;
  logic [lkv_pkg::DataW-1:0] hit_val;
  logic [lkv_pkg::Entries-1:0] hit_vec, valid_vec, occ_mask;

  lkv_pkg::entry_t cell_entry [lkv_pkg::Entries];
  lkv_pkg::entry_t new_entry;

  assign in_key   = s_axis_tdata_i[31:0];
  assign in_value = s_axis_tdata_i[63:32];
  assign is_put   = (s_axis_tuser_i == lkv_pkg::ActPut);

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Keys are unique among valid cells, so the hit vector is one-hot at most.
  always_comb begin
    hit_idx = '0;
    hit_val = '0;
    for (int i = 0; i < lkv_pkg::Entries; i++) begin
      if (hit_vec[i]) begin
        hit_idx = hit_idx | lkv_pkg::IdxW'(i);
      end
      hit_val = hit_val | (cell_entry[i].value & {lkv_pkg::DataW{hit_vec[i]}});
      valid_vec[i] = cell_entry[i].valid;
      occ_mask[i]  = (lkv_pkg::CntW'(i) < occ_q);
    end
  end

  assign any_hit = |hit_vec;

  always_comb begin
    if (capacity_q == '0) begin
      eff_cap = lkv_pkg::CntW'(1);
    end else if (lkv_pkg::CntW'(capacity_q) > lkv_pkg::CntW'(lkv_pkg::Entries)) begin
      eff_cap = lkv_pkg::CntW'(lkv_pkg::Entries);
    end else begin
      eff_cap = lkv_pkg::CntW'(capacity_q);
    end
  end

  assign insert = (occ_q < eff_cap);

  // Deepest cell that shifts: the hit position, the first free cell on an insert,
  // or the least recent cell when a put of a new key must evict.
  always_comb begin
    if (any_hit) begin
      limit = lkv_pkg::CntW'(hit_idx);
    end else if (insert) begin
      limit = occ_q;
    end else begin
      limit = occ_q - lkv_pkg::CntW'(1);
    end
  end

  assign upd  = in_acc && (any_hit || is_put);
  assign grow = in_acc && is_put && !any_hit && insert;

  assign new_entry.valid = 1'b1;
  assign new_entry.key   = in_key;
  assign new_entry.value = is_put ? in_value : hit_val;

  for (genvar g = 0; g < lkv_pkg::Entries; g++) begin : g_cell
    lkv_pkg::cell_ctrl_t ctrl;
    lkv_pkg::entry_t     prev;

    assign ctrl.load = upd && (lkv_pkg::CntW'(g) <= limit);
    assign ctrl.key  = in_key;

    if (g == 0) begin : g_head
      assign prev = new_entry;
    end else begin : g_body
      assign prev = cell_entry[g-1];
    end

    lkv_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .prev_i  (prev),
      .entry_o (cell_entry[g]),
      .match_o (hit_vec[g])
    );
  end

  always_comb begin
    occ_d = occ_q;
    if (grow) begin
      occ_d = occ_q + lkv_pkg::CntW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    out_data_d  = out_data_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_acc) begin
      out_valid_d = 1'b1;
      out_found_d = any_hit;
      if (is_put) begin
        out_data_d = '0;
      end else if (any_hit) begin
        out_data_d = hit_val;
      end else begin
        out_data_d = '1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= lkv_pkg::CapReset;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_found_q <= out_found_d;
    out_data_q  <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_found_q;
  assign m_axis_tdata_o  = out_data_q;

  `LKV_ASSERT(a_single_hit, $onehot0(hit_vec), "more than one cell matched the key")
  `LKV_ASSERT(a_occ_bound, occ_q <= lkv_pkg::CntW'(lkv_pkg::Entries), "occupancy overflow")
  `LKV_ASSERT(a_valid_prefix, valid_vec == occ_mask, "valid cells do not match occupancy")
  `LKV_ASSERT(a_insert_grows, grow |=> occ_q == $past(occ_q) + lkv_pkg::CntW'(1), "no growth")
  `LKV_ASSERT(a_result_follows, in_acc |=> m_axis_tvalid_o, "accepted item gave no result")
  `LKV_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (!m_axis_tvalid_o && occ_q == '0), "not reset")

endmodule
